>>> rtl/core/dtq_pkg.sv
// Shared types and constants of the deadline timer queue.
`timescale 1ns / 1ps
package dtq_pkg;

  localparam int unsigned MAX_FIRE = 16;
  localparam int unsigned FIRE_CNT_BITS = $clog2(MAX_FIRE + 1);

  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_TICK   = 2'd2;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_WRITE,
    CMD_CLEAR,
    CMD_FIRE,
    CMD_CLR_DONE
  } dtq_cmd_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [47:0] deadline;
    logic [31:0] interval;
    logic [31:0] target_id;
    logic [47:0] now;
  } dtq_in_t;

  typedef struct packed {
    logic [31:0] new_id;
    logic        full_res;
    logic        found;
    logic        fired;
    logic [31:0] fired_id;
    logic        last;
    logic        pending;
    logic [47:0] next_deadline;
  } dtq_out_t;

endpackage

>>> rtl/core/deadline_timer_queue.sv
// Deadline timer queue: control sequencer and the chain of timer slots.
// Add, remove and unused modes: after acceptance the command executes, a sweep starts, and
// the result is presented once the sweep token leaves the last slot. Tick: a first sweep,
// then per fired timer a fire, restart, sweep and result; the sweep token walks the slot
// chain one cell per cycle. One item is in work at a time and the next is taken once the
// last result leaves.
// Reset empties every slot and clears the id counter; no clearing pass is needed.
`timescale 1ns / 1ps
module deadline_timer_queue
  import dtq_pkg::*;
#(
  parameter int unsigned TIMER_SLOTS = 16,
  parameter int unsigned TIME_BITS   = 48,
  parameter int unsigned ID_BITS     = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  dtq_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output dtq_out_t out_data_o
);

  localparam int unsigned SLOT_BITS = $clog2(TIMER_SLOTS);

  typedef struct packed {
    logic                 vld;
    logic                 found;
    logic [TIME_BITS-1:0] sel_dl;
    logic [ID_BITS-1:0]   sel_id;
    logic [SLOT_BITS-1:0] sel_slot;
    logic                 any;
    logic [TIME_BITS-1:0] min_dl;
  } tok_t;

  typedef struct packed {
    dtq_cmd_e             op;
    logic [SLOT_BITS-1:0] slot;
    logic [TIME_BITS-1:0] dl;
    logic [31:0]          iv;
    logic [ID_BITS-1:0]   id;
    logic [31:0]          tid;
    logic [TIME_BITS-1:0] now;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXEC, ST_START, ST_SWEEP, ST_FIRE, ST_OUT
  } state_e;

  state_e                   state_q;
  logic [1:0]               mode_q;
  logic [TIME_BITS-1:0]     dl_q, now_q;
  logic [31:0]              iv_q, tid_q;
  logic [ID_BITS-1:0]       last_id_q, prev_id_q, sel_id_q, next_id;
  logic [SLOT_BITS-1:0]     sel_slot_q;
  logic [FIRE_CNT_BITS-1:0] k_q;
  logic                     more_q, more;
  dtq_out_t                 res_q, res_d;
  logic                     out_valid_q;
  dtq_out_t                 out_q, out_d;

  logic [TIMER_SLOTS-1:0]   valid_w, match_w;
  tok_t                     tok_w [TIMER_SLOTS+1];
  cmd_t                     cmd;
  logic                     has_free, has_hit;
  logic [SLOT_BITS-1:0]     free_slot, hit_slot;
  tok_t                     tail;

  // Lowest free slot and lowest slot holding the target id.
  always_comb begin
    has_free  = 1'b0;
    has_hit   = 1'b0;
    free_slot = '0;
    hit_slot  = '0;
    for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
      if (!valid_w[i]) begin
        has_free  = 1'b1;
        free_slot = SLOT_BITS'(i);
      end
      if (match_w[i]) begin
        has_hit  = 1'b1;
        hit_slot = SLOT_BITS'(i);
      end
    end
  end

  always_comb begin
    next_id = last_id_q + 1'b1;
    if (next_id == '0) next_id = ID_BITS'(1);
  end

  always_comb begin
    cmd.op   = CMD_NONE;
    cmd.slot = sel_slot_q;
    cmd.dl   = dl_q;
    cmd.iv   = iv_q;
    cmd.id   = next_id;
    cmd.tid  = tid_q;
    cmd.now  = now_q;
    if (state_q == ST_EXEC) begin
      case (mode_q)
        MODE_ADD: if (has_free) begin
          cmd.op   = CMD_WRITE;
          cmd.slot = free_slot;
        end
        MODE_REMOVE: if (has_hit) begin
          cmd.op   = CMD_CLEAR;
          cmd.slot = hit_slot;
        end
        MODE_TICK: cmd.op = CMD_CLR_DONE;
        default: ;
      endcase
    end else if (state_q == ST_FIRE) begin
      cmd.op = CMD_FIRE;
    end
  end

  always_comb begin
    tok_w[0]     = '0;
    tok_w[0].vld = (state_q == ST_START);
  end

  for (genvar g = 0; g < TIMER_SLOTS; g++) begin : g_cell
    dtq_cell #(
      .TIME_BITS(TIME_BITS),
      .ID_BITS  (ID_BITS),
      .SLOT_BITS(SLOT_BITS),
      .IDX      (g),
      .cmd_t    (cmd_t),
      .tok_t    (tok_t)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd),
      .tok_i  (tok_w[g]),
      .tok_o  (tok_w[g+1]),
      .valid_o(valid_w[g]),
      .match_o(match_w[g])
    );
  end

  assign tail = tok_w[TIMER_SLOTS];
  assign more = tail.found && (k_q < FIRE_CNT_BITS'(MAX_FIRE));

  always_comb begin
    res_d          = '0;
    res_d.last     = 1'b1;
    res_d.full_res = (mode_q == MODE_ADD) && !has_free;
    res_d.new_id   = (mode_q == MODE_ADD && has_free) ? 32'(next_id) : '0;
    res_d.found    = (mode_q == MODE_REMOVE) && has_hit;
  end

  always_comb begin
    out_d               = res_q;
    out_d.pending       = tail.any;
    out_d.next_deadline = tail.any ? 48'(tail.min_dl) : '0;
    if (mode_q == MODE_TICK && k_q != '0) begin
      out_d.fired    = 1'b1;
      out_d.fired_id = 32'(prev_id_q);
      out_d.last     = !more;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      last_id_q   <= '0;
      k_q         <= '0;
      more_q      <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: if (in_valid_i) begin
          k_q     <= '0;
          more_q  <= 1'b0;
          state_q <= ST_EXEC;
        end
        ST_EXEC: begin
          if (mode_q == MODE_ADD && has_free) last_id_q <= next_id;
          state_q <= ST_START;
        end
        ST_START: state_q <= ST_SWEEP;
        ST_SWEEP: if (tail.vld) begin
          if (mode_q != MODE_TICK) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_OUT;
          end else if (k_q != '0) begin
            more_q      <= more;
            out_valid_q <= 1'b1;
            state_q     <= ST_OUT;
          end else if (more) begin
            state_q <= ST_FIRE;
          end else begin
            out_valid_q <= 1'b1;
            state_q     <= ST_OUT;
          end
        end
        ST_FIRE: begin
          k_q     <= k_q + 1'b1;
          state_q <= ST_START;
        end
        ST_OUT: if (!out_stall_i) begin
          out_valid_q <= 1'b0;
          state_q     <= more_q ? ST_FIRE : ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      mode_q <= in_data_i.mode;
      dl_q   <= TIME_BITS'(in_data_i.deadline);
      iv_q   <= in_data_i.interval;
      tid_q  <= in_data_i.target_id;
      now_q  <= TIME_BITS'(in_data_i.now);
    end
    if (state_q == ST_EXEC) res_q <= res_d;
    if (state_q == ST_SWEEP && tail.vld) begin
      sel_slot_q <= tail.sel_slot;
      sel_id_q   <= tail.sel_id;
      out_q      <= out_d;
    end
    if (state_q == ST_FIRE) prev_id_q <= sel_id_q;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> rtl/core/dtq_cell.sv
// One timer slot of the chain: storage plus one stage of the min-search sweep.
`timescale 1ns / 1ps
module dtq_cell
  import dtq_pkg::*;
#(
  parameter int unsigned TIME_BITS = 48,
  parameter int unsigned ID_BITS   = 32,
  parameter int unsigned SLOT_BITS = 4,
  parameter int unsigned IDX       = 0,
  parameter type         cmd_t     = logic,
  parameter type         tok_t     = logic
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t cmd_i,
  input  tok_t tok_i,
  output tok_t tok_o,
  output logic valid_o,
  output logic match_o
);

  localparam int unsigned SUM_W = ((TIME_BITS > 32) ? TIME_BITS : 32) + 1;

  logic                 valid_q, done_q;
  logic [TIME_BITS-1:0] dl_q;
  logic [31:0]          iv_q;
  logic [ID_BITS-1:0]   id_q;
  logic                 tok_vld_q;
  tok_t                 tok_q, tok_d;
  logic                 hit, elig, better;
  logic [SUM_W-1:0]     sum;
  logic [TIME_BITS-1:0] rearm;

  assign hit = (cmd_i.slot == SLOT_BITS'(IDX));
  assign valid_o = valid_q;
  assign match_o = valid_q && (32'(id_q) == cmd_i.tid);

  // Saturating re-arm time.
  assign sum = SUM_W'(cmd_i.now) + SUM_W'(iv_q);
  assign rearm = ((sum >> TIME_BITS) != '0) ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      case (cmd_i.op)
        CMD_WRITE: if (hit) valid_q <= 1'b1;
        CMD_CLEAR: if (hit) valid_q <= 1'b0;
        CMD_FIRE: if (hit) begin
          done_q <= 1'b1;
          if (iv_q == '0) valid_q <= 1'b0;
        end
        CMD_CLR_DONE: done_q <= 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == CMD_WRITE && hit) begin
      dl_q <= cmd_i.dl;
      iv_q <= cmd_i.iv;
      id_q <= cmd_i.id;
    end else if (cmd_i.op == CMD_FIRE && hit && iv_q != '0) begin
      dl_q <= rearm;
    end
  end

  // Sweep stage: fold this slot into the running best and running minimum.
  assign elig = valid_q && !done_q && (dl_q <= cmd_i.now);
  assign better = elig && (!tok_i.found || (dl_q < tok_i.sel_dl) ||
                           ((dl_q == tok_i.sel_dl) && (id_q < tok_i.sel_id)));

  always_comb begin
    tok_d = tok_i;
    if (better) begin
      tok_d.found    = 1'b1;
      tok_d.sel_dl   = dl_q;
      tok_d.sel_id   = id_q;
      tok_d.sel_slot = SLOT_BITS'(IDX);
    end
    if (valid_q && (!tok_i.any || dl_q < tok_i.min_dl)) begin
      tok_d.any    = 1'b1;
      tok_d.min_dl = dl_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_vld_q <= 1'b0;
    end else begin
      tok_vld_q <= tok_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
  end

  always_comb begin
    tok_o = tok_q;
    tok_o.vld = tok_vld_q;
  end

endmodule

>>> test/deadline_timer_queue_test.sv
// Self-checking testbench of the deadline timer queue with a built-in predictor.
`timescale 1ns / 1ps
module deadline_timer_queue_test;
  import dtq_pkg::*;

  localparam int unsigned SLOTS = 16;
  localparam logic [1:0] MODE_IDLE = 2'd3;
  localparam logic [47:0] TIME_TOP = 48'hFFFF_FFFF_FFFF;
  localparam int unsigned CYCLE_LIMIT = 1500000;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  dtq_in_t in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  dtq_out_t out_data_o;

  deadline_timer_queue u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // Predictor state: a private copy of the timer table.
  logic        tmr_valid[SLOTS];
  logic [47:0] tmr_deadline[SLOTS];
  logic [31:0] tmr_interval[SLOTS];
  logic [31:0] tmr_id[SLOTS];
  logic [31:0] issued_id;

  dtq_in_t  pending_items[$];
  dtq_out_t expected_results[$];
  int unsigned accepted_cnt;
  int unsigned result_cnt;
  int unsigned fire_cnt;
  int unsigned full_cnt;
  int unsigned error_cnt;
  int unsigned cycle_cnt;
  int unsigned hold_cycles;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic dtq_out_t status_result();
    dtq_out_t r;
    r = '0;
    r.last = 1'b1;
    for (int i = 0; i < SLOTS; i++) begin
      if (tmr_valid[i] && (!r.pending || tmr_deadline[i] < r.next_deadline)) begin
        r.next_deadline = tmr_deadline[i];
        r.pending = 1'b1;
      end
    end
    return r;
  endfunction

  // Applies one transaction to the table and queues the results it causes.
  task automatic predict_timer_results(input dtq_in_t item);
    dtq_out_t r;
    logic done[SLOTS];
    int sel;
    int k;
    logic [48:0] sum;
    case (item.mode)
      MODE_ADD: begin
        sel = -1;
        for (int i = SLOTS - 1; i >= 0; i--) if (!tmr_valid[i]) sel = i;
        if (sel < 0) begin
          r = status_result();
          r.full_res = 1'b1;
          full_cnt++;
        end else begin
          issued_id = issued_id + 1;
          if (issued_id == 0) issued_id = 1;
          tmr_valid[sel] = 1'b1;
          tmr_deadline[sel] = item.deadline;
          tmr_interval[sel] = item.interval;
          tmr_id[sel] = issued_id;
          r = status_result();
          r.new_id = issued_id;
        end
        expected_results.push_back(r);
      end
      MODE_REMOVE: begin
        sel = -1;
        for (int i = SLOTS - 1; i >= 0; i--)
          if (tmr_valid[i] && tmr_id[i] == item.target_id) sel = i;
        if (sel >= 0) tmr_valid[sel] = 1'b0;
        r = status_result();
        r.found = (sel >= 0);
        expected_results.push_back(r);
      end
      MODE_TICK: begin
        for (int i = 0; i < SLOTS; i++) done[i] = 1'b0;
        k = 0;
        while (k < MAX_FIRE) begin
          sel = -1;
          for (int i = 0; i < SLOTS; i++) begin
            if (tmr_valid[i] && !done[i] && tmr_deadline[i] <= item.now) begin
              if (sel < 0 || tmr_deadline[i] < tmr_deadline[sel] ||
                  (tmr_deadline[i] == tmr_deadline[sel] && tmr_id[i] < tmr_id[sel]))
                sel = i;
            end
          end
          if (sel < 0) break;
          done[sel] = 1'b1;
          if (k > 0) expected_results[$].last = 1'b0;
          if (tmr_interval[sel] != 0) begin
            sum = {1'b0, item.now} + tmr_interval[sel];
            tmr_deadline[sel] = sum[48] ? TIME_TOP : sum[47:0];
          end else begin
            tmr_valid[sel] = 1'b0;
          end
          r = status_result();
          r.fired = 1'b1;
          r.fired_id = tmr_id[sel];
          expected_results.push_back(r);
          fire_cnt++;
          k++;
        end
        if (k == 0) expected_results.push_back(status_result());
      end
      default: expected_results.push_back(status_result());
    endcase
  endtask

  // Driver: offers queued transactions with random gaps; an empty queue leaves the input idle.
  int unsigned send_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i <= '0;
      send_gap <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predict_timer_results(in_data_i);
        accepted_cnt++;
      end
      if (in_valid_i && in_stall_o) begin
        // Hold the stalled transaction.
      end else if (send_gap != 0) begin
        in_valid_i <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_items.size() != 0) begin
        in_valid_i <= 1'b1;
        in_data_i <= pending_items.pop_front();
        send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor and receiver stall.
  int unsigned recv_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        result_cnt++;
        if (expected_results.size() == 0) begin
          $error("unexpected result transaction %p", out_data_o);
          error_cnt++;
        end else begin
          automatic dtq_out_t e = expected_results.pop_front();
          if (out_data_o.new_id !== e.new_id) begin
            $error("new_id: expected %0d, actual %0d", e.new_id, out_data_o.new_id);
            error_cnt++;
          end
          if (out_data_o.full_res !== e.full_res) begin
            $error("full_res: expected %0d, actual %0d", e.full_res, out_data_o.full_res);
            error_cnt++;
          end
          if (out_data_o.found !== e.found) begin
            $error("found: expected %0d, actual %0d", e.found, out_data_o.found);
            error_cnt++;
          end
          if (out_data_o.fired !== e.fired) begin
            $error("fired: expected %0d, actual %0d", e.fired, out_data_o.fired);
            error_cnt++;
          end
          if (out_data_o.fired_id !== e.fired_id) begin
            $error("fired_id: expected %0d, actual %0d", e.fired_id, out_data_o.fired_id);
            error_cnt++;
          end
          if (out_data_o.last !== e.last) begin
            $error("last: expected %0d, actual %0d", e.last, out_data_o.last);
            error_cnt++;
          end
          if (out_data_o.pending !== e.pending) begin
            $error("pending: expected %0d, actual %0d", e.pending, out_data_o.pending);
            error_cnt++;
          end
          if (out_data_o.next_deadline !== e.next_deadline) begin
            $error("next_deadline: expected %0h, actual %0h", e.next_deadline,
                   out_data_o.next_deadline);
            error_cnt++;
          end
        end
      end
      if (hold_cycles != 0) begin
        out_stall_i <= 1'b1;
        hold_cycles <= hold_cycles - 1;
      end else if (recv_gap != 0) begin
        out_stall_i <= 1'b1;
        recv_gap <= recv_gap - 1;
      end else if (out_valid_o && !out_stall_i) begin
        recv_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic dtq_in_t make_item(logic [1:0] m, logic [47:0] dl, logic [31:0] iv,
                                        logic [31:0] tid, logic [47:0] nw);
    dtq_in_t it;
    it.mode = m;
    it.deadline = dl;
    it.interval = iv;
    it.target_id = tid;
    it.now = nw;
    return it;
  endfunction

  function automatic logic [47:0] rand_time();
    return 48'({$urandom(), $urandom()});
  endfunction

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
  endtask

  logic [47:0] clock_ms;
  initial begin
    rst_ni = 1'b0;
    hold_cycles = 0;
    accepted_cnt = 0;
    result_cnt = 0;
    fire_cnt = 0;
    full_cnt = 0;
    error_cnt = 0;
    cycle_cnt = 0;
    issued_id = '0;
    for (int i = 0; i < SLOTS; i++) begin
      tmr_valid[i] = 1'b0;
      tmr_deadline[i] = '0;
      tmr_interval[i] = '0;
      tmr_id[i] = '0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: quiet tick, unused mode, remove miss, extremes, ties and overflow.
    pending_items.push_back(make_item(MODE_TICK, '0, '0, '0, TIME_TOP));
    pending_items.push_back(make_item(MODE_IDLE, TIME_TOP, '1, '1, TIME_TOP));
    pending_items.push_back(make_item(MODE_REMOVE, '0, '0, 32'd5, '0));
    pending_items.push_back(make_item(MODE_ADD, TIME_TOP, '1, '1, '1));
    pending_items.push_back(make_item(MODE_ADD, 48'd100, 32'hFFFF_FFFF, '0, '0));
    pending_items.push_back(make_item(MODE_ADD, 48'd100, 32'd0, '0, '0));
    pending_items.push_back(make_item(MODE_ADD, '0, 32'd50, '0, '0));
    pending_items.push_back(make_item(MODE_TICK, '0, '0, '0, 48'd99));
    pending_items.push_back(make_item(MODE_TICK, '0, '0, '0, 48'd100));
    pending_items.push_back(make_item(MODE_REMOVE, '0, '0, 32'd3, '0));
    pending_items.push_back(make_item(MODE_REMOVE, '0, '0, 32'd3, '0));
    // Repeating timer near the top of time saturates when re-armed.
    pending_items.push_back(make_item(MODE_TICK, '0, '0, '0, TIME_TOP - 48'd1));
    pending_items.push_back(make_item(MODE_TICK, '0, '0, '0, TIME_TOP));
    // Fill the thirteen free slots; the three adds after them are rejected.
    for (int i = 0; i < SLOTS - 1; i++)
      pending_items.push_back(make_item(MODE_ADD, 48'd7, 32'd0, '0, '0));
    pending_items.push_back(make_item(MODE_ADD, 48'd7, 32'd1, '0, '0));
    pending_items.push_back(make_item(MODE_TICK, '0, '0, '0, TIME_TOP));
    wait_drained();

    // Sender pause until drained, then a long receiver hold while the sender keeps going.
    hold_cycles = 400;
    for (int i = 0; i < 12; i++)
      pending_items.push_back(make_item(MODE_ADD, 48'd20 + i, i % 3, '0, '0));
    pending_items.push_back(make_item(MODE_TICK, '0, '0, '0, 48'd1000));
    wait_drained();

    // Random part: a running clock with adds near it, removes of recent ids, ticks, unused mode.
    clock_ms = 48'd5000;
    for (int n = 0; n < 240; n++) begin
      automatic int pick = $urandom_range(0, 99);
      automatic dtq_in_t it;
      it = make_item(MODE_IDLE, rand_time(), $urandom(), $urandom(), rand_time());
      if (pick < 40) begin
        it.mode = MODE_ADD;
        if ($urandom_range(0, 9) != 0) it.deadline = clock_ms + $urandom_range(0, 400);
        if ($urandom_range(0, 9) != 0)
          it.interval = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 300);
      end else if (pick < 60) begin
        it.mode = MODE_REMOVE;
        if ($urandom_range(0, 3) != 0)
          it.target_id = issued_id - $urandom_range(0, 20);
      end else if (pick < 97) begin
        it.mode = MODE_TICK;
        if ($urandom_range(0, 9) != 0) begin
          clock_ms = clock_ms + $urandom_range(0, 250);
          it.now = clock_ms;
        end
      end
      pending_items.push_back(it);
      if (pending_items.size() > 8) @(posedge clk_i);
    end
    wait_drained();
    repeat (200) @(posedge clk_i);

    $display("Covered %0d transactions in, %0d results out, %0d firings, %0d rejected adds.",
             accepted_cnt, result_cnt, fire_cnt, full_cnt);
    if (error_cnt == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
